/* hdl/lcsl_pkg.sv */
// Shared types, constants and codes of the LRU cache set lookup unit.
`default_nettype none

package lcsl_pkg;

    // Geometry of the tag store.
    localparam int NUM_SETS = 64;
    localparam int MAX_WAYS = 8;
    localparam int TAG_BITS = 20;

    // Derived widths.
    localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_BITS;
    localparam int FILL_W   = $clog2(MAX_WAYS + 1);

    // Fixed field widths of the ports.
    localparam int SET_IN_W = 6;
    localparam int WAYS_W   = 4;
    localparam int MEM_W    = 2;

    // Configuration port.
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int CFG_WAYS_IDX = 0;
    localparam logic [ADDR_W-1:0] CFG_WAYS_ADDR = ADDR_W'(4 * CFG_WAYS_IDX);
    localparam logic [WAYS_W-1:0] WAYS_RESET    = WAYS_W'(8);

    // Memory access counts reported per transfer.
    localparam logic [MEM_W-1:0] MEM_NONE = 2'd0;
    localparam logic [MEM_W-1:0] MEM_ONE  = 2'd1;
    localparam logic [MEM_W-1:0] MEM_TWO  = 2'd2;

    // One line of a set.
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                valid;
        logic                dirty;
        logic [AGE_W-1:0]    age;
    } line_t;

    // One memory row holds a whole set plus its fill count.
    typedef struct packed {
        logic [FILL_W-1:0]          fill;
        line_t [MAX_WAYS-1:0]       ways;
    } set_row_t;

    localparam int ROW_BITS = $bits(set_row_t);

    // Access request as held in the lookup stage.
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                alloc;
        logic                wr;
    } access_t;

    // Result of one access.
    typedef struct packed {
        logic             hit;
        logic [MEM_W-1:0] mem;
    } result_t;

endpackage

`default_nettype wire

/* hdl/lru_cache_set_lookup_unit.sv */
// Top level of the LRU cache set lookup unit: handshakes, set memory and forwarding.
`default_nettype none

// Tag store of a set-associative cache with true LRU replacement. Each set is one
// row of a single-read, single-write synchronous memory, so a lookup reads the
// row in the cycle after the transfer, updates it and writes it back while the
// result is loaded into the output register. The unit sustains one transfer per
// cycle while the output is not stalled; a result passes the lookup stage and is
// then held in the output register until taken. Back-to-back accesses to the same
// set are served by forwarding the row being written, and a stalled output holds
// the lookup stage and drops in_ready. Reset takes effect at once through one valid
// flag per set row; there is no clearing pass. ways_in_use is written through the
// APB port at byte address 0 only while idle; the user, not the block, ensures it.
module lru_cache_set_lookup_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lcsl_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [lcsl_pkg::DATA_W-1:0]     pwdata,
    output logic      [lcsl_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    // Access input.
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [lcsl_pkg::SET_IN_W-1:0]   set_index,
    input  wire logic [lcsl_pkg::TAG_BITS-1:0]   tag_value,
    input  wire logic                            allocate,
    input  wire logic                            write_access,
    // Result output.
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 hit,
    output logic      [lcsl_pkg::MEM_W-1:0]      mem_accesses
);
    import lcsl_pkg::*;

    logic                 accept;
    logic                 s1_go;
    logic [SET_BITS-1:0]  set_idx;
    logic                 cfg_wr;
    logic [FILL_W-1:0]    assoc;

    logic [WAYS_W-1:0]    ways_reg;
    logic [NUM_SETS-1:0]  row_ok_reg;
    logic                 s1_valid_reg;
    logic                 out_valid_reg;
    logic                 fwd_valid_reg;
    logic                 fwd_valid_next;

    logic [SET_BITS-1:0]  s1_set_reg;
    access_t              s1_acc_reg;
    logic                 s1_rowok_reg;
    set_row_t             fwd_row_reg;
    result_t              res_reg;

    set_row_t             rd_row;
    set_row_t             row_cur;
    set_row_t             row_next;
    result_t              res_next;

    // Handshake control.
    assign set_idx  = set_index[SET_BITS-1:0];
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == CFG_WAYS_ADDR);
    assign prdata = (paddr == CFG_WAYS_ADDR) ? DATA_W'(ways_reg) : '0;

    // Clamp the associativity to the supported range.
    always_comb
    begin
        if (ways_reg == '0)
        begin
            assoc = FILL_W'(1);
        end
        else if ({1'b0, ways_reg} > (WAYS_W + 1)'(MAX_WAYS))
        begin
            assoc = FILL_W'(MAX_WAYS);
        end
        else
        begin
            assoc = FILL_W'(ways_reg);
        end
    end

    // Set row memory.
    lcsl_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_set_reg),
        .wdata (row_next),
        .re    (accept),
        .raddr (set_idx),
        .rdata (rd_row)
    );

    // Row seen by the lookup stage: forwarded, stored, or reset contents.
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            row_cur = fwd_row_reg;
        end
        else if (s1_rowok_reg)
        begin
            row_cur = rd_row;
        end
        else
        begin
            row_cur = '0;
        end
    end

    lcsl_update u_update (
        .row_in  (row_cur),
        .acc     (s1_acc_reg),
        .assoc   (assoc),
        .row_out (row_next),
        .res     (res_next)
    );

    // Forward the written row when the next access reads the same set.
    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        if (accept)
        begin
            fwd_valid_next = s1_go && (s1_set_reg == set_idx);
        end
        else if (s1_go)
        begin
            fwd_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg      <= WAYS_RESET;
            row_ok_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                ways_reg <= pwdata[WAYS_W-1:0];
            end
            if (s1_go)
            begin
                row_ok_reg[s1_set_reg] <= 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg       <= set_idx;
            s1_acc_reg.tag   <= tag_value;
            s1_acc_reg.alloc <= allocate;
            s1_acc_reg.wr    <= write_access;
            s1_rowok_reg     <= row_ok_reg[set_idx];
            fwd_row_reg      <= row_next;
        end
        if (s1_go)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = res_reg.hit;
    assign mem_accesses = res_reg.mem;

    // A stalled lookup stage must block new transfers.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while lookup stage is stalled");

    // Forwarding is only armed for an access held in the lookup stage.
    a_fwd_with_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forwarding armed without an access in the lookup stage");

    // A hit never costs a memory access.
    a_hit_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (mem_accesses == MEM_NONE))
        else $error("hit reported with memory accesses");

    // The fill count written back never exceeds the number of ways.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |-> (row_next.fill <= FILL_W'(MAX_WAYS)))
        else $error("fill count exceeds the number of ways");

endmodule

`default_nettype wire

/* hdl/lcsl_ram.sv */
// Simple dual-port synchronous RAM with registered read.
`default_nettype none

module lcsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/lcsl_update.sv */
// Hit detection, replacement choice and LRU update of one set row.
`default_nettype none

module lcsl_update (
    input  wire lcsl_pkg::set_row_t          row_in,
    input  wire lcsl_pkg::access_t           acc,
    input  wire logic [lcsl_pkg::FILL_W-1:0] assoc,
    output lcsl_pkg::set_row_t               row_out,
    output lcsl_pkg::result_t                res
);
    import lcsl_pkg::*;

    logic                hit_found;
    logic [WAY_BITS-1:0] hit_idx;
    logic                free_found;
    logic [WAY_BITS-1:0] free_idx;
    logic                vic_found;
    logic [WAY_BITS-1:0] vic_idx;
    logic [AGE_W-1:0]    oldest;

    // Tag match: the first valid way that holds the tag.
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (!hit_found && row_in.ways[w].valid && row_in.ways[w].tag == acc.tag)
            begin
                hit_found = 1'b1;
                hit_idx   = WAY_BITS'(w);
            end
        end
    end

    // First free way, usable only while the set is below its associativity.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (!free_found && !row_in.ways[w].valid)
            begin
                free_found = 1'b1;
                free_idx   = WAY_BITS'(w);
            end
        end
        if (row_in.fill >= assoc)
        begin
            free_found = 1'b0;
        end
    end

    // Victim: the first valid way with the highest age.
    always_comb
    begin
        vic_found = 1'b0;
        vic_idx   = '0;
        oldest    = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (row_in.ways[w].valid && (!vic_found || row_in.ways[w].age > oldest))
            begin
                vic_found = 1'b1;
                vic_idx   = WAY_BITS'(w);
                oldest    = row_in.ways[w].age;
            end
        end
    end

    // New row contents and the access count.
    always_comb
    begin
        logic [WAY_BITS-1:0] slot;
        logic                grow;
        logic                evict_dirty;
        logic [AGE_W-1:0]    hit_age;

        row_out     = row_in;
        res.hit     = 1'b0;
        res.mem     = MEM_ONE;
        slot        = '0;
        grow        = 1'b0;
        evict_dirty = 1'b0;
        hit_age     = row_in.ways[hit_idx].age;

        if (hit_found)
        begin
            // Lines more recent than the hit line move back by one.
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (row_in.ways[w].valid && row_in.ways[w].age < hit_age)
                begin
                    row_out.ways[w].age = row_in.ways[w].age + 1'b1;
                end
            end
            row_out.ways[hit_idx].age = '0;
            if (acc.wr)
            begin
                row_out.ways[hit_idx].dirty = 1'b1;
            end
            res.hit = 1'b1;
            res.mem = MEM_NONE;
        end
        else if (acc.alloc)
        begin
            if (free_found)
            begin
                slot = free_idx;
                grow = 1'b1;
            end
            else if (vic_found)
            begin
                slot        = vic_idx;
                evict_dirty = row_in.ways[vic_idx].dirty;
            end
            else
            begin
                // An empty set takes way 0 as a free way.
                slot = '0;
                grow = 1'b1;
            end

            // Every other valid line ages by one.
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (row_in.ways[w].valid)
                begin
                    row_out.ways[w].age = row_in.ways[w].age + 1'b1;
                end
            end
            row_out.ways[slot].valid = 1'b1;
            row_out.ways[slot].tag   = acc.tag;
            row_out.ways[slot].dirty = acc.wr;
            row_out.ways[slot].age   = '0;
            if (grow)
            begin
                row_out.fill = row_in.fill + 1'b1;
            end
            res.mem = evict_dirty ? MEM_TWO : MEM_ONE;
        end
    end

endmodule

`default_nettype wire

/* bench/lru_cache_set_lookup_unit_checker.sv */
// Checker of the LRU cache set lookup unit: predicts each access result and compares it.
module lru_cache_set_lookup_unit_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcsl_pkg::ADDR_W-1:0]       paddr,
    input  logic [lcsl_pkg::DATA_W-1:0]       pwdata,
    input  logic [lcsl_pkg::DATA_W-1:0]       prdata,
    input  logic                              pready,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [lcsl_pkg::SET_IN_W-1:0]     set_index,
    input  logic [lcsl_pkg::TAG_BITS-1:0]     tag_value,
    input  logic                              allocate,
    input  logic                              write_access,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              hit,
    input  logic [lcsl_pkg::MEM_W-1:0]        mem_accesses,
    output int                                mismatches,
    output int                                outstanding
);
    import lcsl_pkg::*;

    // Shadow copy of the tag store and of the associativity register.
    bit [TAG_BITS-1:0] line_tag   [NUM_SETS][MAX_WAYS];
    bit                line_valid [NUM_SETS][MAX_WAYS];
    bit                line_dirty [NUM_SETS][MAX_WAYS];
    bit [AGE_W-1:0]    line_age   [NUM_SETS][MAX_WAYS];
    bit [FILL_W-1:0]   fill_cnt   [NUM_SETS];
    bit [WAYS_W-1:0]   ways_cfg;

    result_t result_q [$];
    int      fail_total;

    // Looks up one access in the shadow store, updates it and returns the result.
    function automatic result_t predict_access(input logic [SET_IN_W-1:0] set_in,
                                               input logic [TAG_BITS-1:0] tag,
                                               input logic alloc,
                                               input logic wr);
        int             s;
        int             assoc;
        int             found;
        int             slot;
        int             victim;
        bit [AGE_W-1:0] rank_limit;
        bit [AGE_W-1:0] oldest;
        result_t        res;
        s = int'(set_in) % NUM_SETS;
        assoc = int'(ways_cfg);
        if (assoc < 1)
            assoc = 1;
        if (assoc > MAX_WAYS)
            assoc = MAX_WAYS;
        found = -1;
        for (int w = 0; w < MAX_WAYS; w++)
            if (found < 0 && line_valid[s][w] && line_tag[s][w] == tag)
                found = w;
        res.hit = 1'b0;
        res.mem = MEM_NONE;
        if (found >= 0)
        begin
            // A hit promotes the line; only lines younger than it grow older.
            rank_limit = line_age[s][found];
            for (int w = 0; w < MAX_WAYS; w++)
                if (line_valid[s][w] && line_age[s][w] < rank_limit)
                    line_age[s][w]++;
            line_age[s][found] = '0;
            if (wr)
                line_dirty[s][found] = 1'b1;
            res.hit = 1'b1;
        end
        else if (alloc)
        begin
            res.mem = MEM_ONE;
            slot = -1;
            if (int'(fill_cnt[s]) < assoc)
                for (int w = 0; w < MAX_WAYS; w++)
                    if (slot < 0 && !line_valid[s][w])
                        slot = w;
            if (slot >= 0)
                fill_cnt[s]++;
            else
            begin
                // The set is full: the oldest valid line is evicted, first way on a tie.
                victim = -1;
                oldest = '0;
                for (int w = 0; w < MAX_WAYS; w++)
                    if (line_valid[s][w] && (victim < 0 || line_age[s][w] > oldest))
                    begin
                        victim = w;
                        oldest = line_age[s][w];
                    end
                if (victim < 0)
                begin
                    slot = 0;
                    fill_cnt[s]++;
                end
                else
                begin
                    slot = victim;
                    if (line_dirty[s][slot])
                        res.mem = MEM_TWO;
                    line_valid[s][slot] = 1'b0;
                end
            end
            // The new line enters as most recently used, so every other line ages.
            for (int w = 0; w < MAX_WAYS; w++)
                if (line_valid[s][w])
                    line_age[s][w]++;
            line_valid[s][slot] = 1'b1;
            line_tag[s][slot]   = tag;
            line_dirty[s][slot] = wr;
            line_age[s][slot]   = '0;
        end
        else
            res.mem = MEM_ONE;
        return res;
    endfunction

    // Watch the configuration port and both channels.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                fill_cnt[s] = '0;
                for (int w = 0; w < MAX_WAYS; w++)
                begin
                    line_tag[s][w]   = '0;
                    line_valid[s][w] = 1'b0;
                    line_dirty[s][w] = 1'b0;
                    line_age[s][w]   = '0;
                end
            end
            ways_cfg = WAYS_RESET;
            result_q.delete();
            fail_total = 0;
        end
        else
        begin
            // Register writes update the shadow; reads must return it.
            if (psel && penable && pready && paddr == CFG_WAYS_ADDR)
            begin
                if (pwrite)
                    ways_cfg = pwdata[WAYS_W-1:0];
                else if (prdata !== DATA_W'(ways_cfg))
                begin
                    $display("%0t: ways_in_use readback mismatch, expected %0d, actual %0h",
                             $time, ways_cfg, prdata);
                    fail_total++;
                end
            end
            // Each result transfer is checked against the oldest prediction.
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result, actual hit=%0b mem_accesses=%0d",
                             $time, hit, mem_accesses);
                    fail_total++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want.hit, hit);
                        fail_total++;
                    end
                    if (mem_accesses !== want.mem)
                    begin
                        $display("%0t: mem_accesses mismatch, expected %0d, actual %0d",
                                 $time, want.mem, mem_accesses);
                        fail_total++;
                    end
                end
            end
            if (in_valid && in_ready)
                result_q.push_back(predict_access(set_index, tag_value, allocate,
                                                  write_access));
        end
        mismatches  <= fail_total;
        outstanding <= result_q.size();
    end

endmodule

/* bench/lru_cache_set_lookup_unit_tb.sv */
// Testbench top of the LRU cache set lookup unit: stimulus, watchdog and verdict.
module lru_cache_set_lookup_unit_tb;
    import lcsl_pkg::*;

    localparam int STALL_LIMIT   = 500;
    localparam int PHASE_ITEMS   = 88;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOT_SETS      = 3;
    localparam int POOL_MAX      = 12;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [SET_IN_W-1:0] set_index    = '0;
    logic [TAG_BITS-1:0] tag_value    = '0;
    logic                allocate     = 1'b0;
    logic                write_access = 1'b0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic                hit;
    logic [MEM_W-1:0]    mem_accesses;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    logic [SET_IN_W-1:0] hot_sets [HOT_SETS];
    logic [TAG_BITS-1:0] tag_pool [POOL_MAX];
    int                  pool_size;

    lru_cache_set_lookup_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .set_index    (set_index),
        .tag_value    (tag_value),
        .allocate     (allocate),
        .write_access (write_access),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .mem_accesses (mem_accesses)
    );

    lru_cache_set_lookup_unit_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .set_index    (set_index),
        .tag_value    (tag_value),
        .allocate     (allocate),
        .write_access (write_access),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .mem_accesses (mem_accesses),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The run ends as a failure when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("lru_cache_set_lookup_unit regression: fail");
            $finish;
        end
    end

    // The result side holds out_ready low for a random stall before each transfer, none while no_idle is set.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offers one access after a random gap and returns at the edge of its transfer.
    task automatic issue_access(input logic [SET_IN_W-1:0] s, input logic [TAG_BITS-1:0] t,
                                input logic alloc, input logic wr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        set_index    <= s;
        tag_value    <= t;
        allocate     <= alloc;
        write_access <= wr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // A setup phase, then an access phase that waits for pready; the caller releases the port.
    task automatic apb_access(input logic wr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_WAYS_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // Writes the associativity register and reads it back.
    task automatic set_ways(input logic [WAYS_W-1:0] ways);
        apb_access(1'b1, DATA_W'(ways));
        apb_access(1'b0, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stops offering accesses and waits until every result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Random accesses concentrated on a few sets and tags so that lines hit and evict.
    task automatic random_phase(input logic [WAYS_W-1:0] ways, input int count);
        logic [SET_IN_W-1:0] s;
        logic [TAG_BITS-1:0] t;
        set_ways(ways);
        no_idle   = ($urandom_range(0, 3) == 0);
        pool_size = $urandom_range(3, POOL_MAX);
        foreach (hot_sets[i])
            hot_sets[i] = SET_IN_W'($urandom_range(0, 63));
        foreach (tag_pool[i])
            tag_pool[i] = TAG_BITS'($urandom);
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 8)
                s = hot_sets[$urandom_range(0, HOT_SETS - 1)];
            else
                s = SET_IN_W'($urandom_range(0, 63));
            if ($urandom_range(0, 9) < 8)
                t = tag_pool[$urandom_range(0, pool_size - 1)];
            else
                t = TAG_BITS'($urandom);
            issue_access(s, t, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset associativity: bypass miss, fills and hits without a write.
        issue_access(6'd0, 20'h00000, 1'b0, 1'b0);
        issue_access(6'd63, 20'hFFFFF, 1'b1, 1'b1);
        issue_access(6'd63, 20'hFFFFF, 1'b0, 1'b0);
        issue_access(6'd63, 20'h00000, 1'b1, 1'b0);
        issue_access(6'd63, 20'hFFFFF, 1'b1, 1'b0);
        drain();

        // Direct mapped: dirty and clean evictions, a hit and a bypass.
        set_ways(4'd1);
        issue_access(6'd5, 20'h12345, 1'b1, 1'b1);
        issue_access(6'd5, 20'hABCDE, 1'b1, 1'b0);
        issue_access(6'd5, 20'h55555, 1'b1, 1'b1);
        issue_access(6'd5, 20'h55555, 1'b0, 1'b0);
        issue_access(6'd5, 20'h12345, 1'b0, 1'b1);
        drain();

        // An associativity of zero behaves as one.
        set_ways(4'd0);
        issue_access(6'd9, 20'hAAAAA, 1'b1, 1'b0);
        issue_access(6'd9, 20'h00001, 1'b1, 1'b1);
        issue_access(6'd9, 20'hAAAAA, 1'b1, 1'b0);
        drain();

        // Values above the way count behave as the full way count.
        set_ways(4'd15);
        issue_access(6'd20, 20'h00001, 1'b1, 1'b1);
        issue_access(6'd20, 20'h00002, 1'b1, 1'b0);
        issue_access(6'd20, 20'h00003, 1'b1, 1'b1);
        issue_access(6'd20, 20'h00004, 1'b1, 1'b0);
        drain();

        // Associativity lowered below the fill: misses replace, old lines still hit.
        set_ways(4'd2);
        issue_access(6'd20, 20'h00005, 1'b1, 1'b0);
        issue_access(6'd20, 20'h00002, 1'b0, 1'b0);
        issue_access(6'd20, 20'h00006, 1'b1, 1'b1);
        issue_access(6'd20, 20'h00003, 1'b1, 1'b1);
        issue_access(6'd20, 20'h00007, 1'b0, 1'b0);
        drain();

        random_phase(4'd3, PHASE_ITEMS);
        random_phase(4'd8, PHASE_ITEMS);
        random_phase(4'd1, PHASE_ITEMS);
        random_phase(WAYS_W'($urandom_range(0, 15)), PHASE_ITEMS);
        random_phase(WAYS_W'($urandom_range(1, 8)), PHASE_ITEMS);
        random_phase(4'd4, PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("lru_cache_set_lookup_unit regression: pass");
        else
            $display("lru_cache_set_lookup_unit regression: fail");
        $finish;
    end

endmodule
